FILE: rtl/track_motion_estimator_core_macros.svh
// Assertion macros for the track motion estimator.
// Used by the top level only; clk_i and rst_ni must be visible where expanded.
`ifndef TRACK_MOTION_ESTIMATOR_CORE_MACROS_SVH
`define TRACK_MOTION_ESTIMATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked on every clock edge outside reset.
`define TME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication.
`define TME_ASSERT_IMP(lbl, ante, cons, msg) \
  `TME_ASSERT(lbl, (ante) |-> (cons), msg)
// Next-cycle implication.
`define TME_ASSERT_NXT(lbl, ante, cons, msg) \
  `TME_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define TME_ASSERT(lbl, prop, msg)
`define TME_ASSERT_IMP(lbl, ante, cons, msg)
`define TME_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/tme_pkg.sv
// Shared types, constants and tables of the track motion estimator.
// No dependencies.
`default_nettype none
package tme_pkg;

  localparam int unsigned MAX_DEPTH_DEF  = 64;
  localparam int unsigned COORD_BITS_DEF = 24;

  // Configuration port
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIST_LEN = 1'b0,
    REG_SMOOTH   = 1'b1
  } cfg_reg_e;
  localparam logic [CFG_W-1:0] HIST_LEN_RST = 7'd16;
  localparam logic [CFG_W-1:0] SMOOTH_RST   = 7'd4;

  // Result field widths
  localparam int unsigned SPEED_W = 24;
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned CONF_W  = 16;
  localparam logic [CONF_W-1:0] CONF_FULL = 16'h8000;

  // Heading weights (Q16) and their sum
  localparam int unsigned WT_W   = 17;
  localparam int unsigned NUM_WT = 9;
  localparam int unsigned WS_W   = 19;

  // Angle arithmetic
  localparam int unsigned ANG_IN_W = 31;
  localparam int unsigned Z_W      = 21;
  localparam int unsigned CORDIC_N = 17;
  localparam int unsigned ATAN_W   = 16;
  localparam logic signed [Z_W-1:0] PI_Q16        = 21'sd205887;
  localparam logic signed [Z_W-1:0] HEADING_LIMIT = 21'sd25736;

  // Status of an iterative arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_FETCH, S_LOAD, S_SQX, S_SQY, S_ACCX, S_ACCY,
    S_ROOT, S_ROOT_WAIT, S_NEXT, S_SPD, S_SPD_WAIT, S_NEG, S_NORM,
    S_MX, S_MY, S_MAG, S_MAG_WAIT, S_CMP, S_CONF_WAIT, S_ANG, S_ANG_WAIT,
    S_DONE
  } tme_state_e;

  function automatic logic [WT_W-1:0] fall_wt(input logic [3:0] idx);
    logic [WT_W-1:0] w;
    unique case (idx)
      4'd0: w = 17'd65536;
      4'd1: w = 17'd58982;
      4'd2: w = 17'd53084;
      4'd3: w = 17'd47776;
      4'd4: w = 17'd42998;
      4'd5: w = 17'd38698;
      4'd6: w = 17'd34829;
      4'd7: w = 17'd31346;
      4'd8: w = 17'd28211;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [ATAN_W-1:0] atan_q16(input logic [4:0] idx);
    logic [ATAN_W-1:0] a;
    unique case (idx)
      5'd0:  a = 16'd51472;
      5'd1:  a = 16'd30386;
      5'd2:  a = 16'd16055;
      5'd3:  a = 16'd8150;
      5'd4:  a = 16'd4091;
      5'd5:  a = 16'd2047;
      5'd6:  a = 16'd1024;
      5'd7:  a = 16'd512;
      5'd8:  a = 16'd256;
      5'd9:  a = 16'd128;
      5'd10: a = 16'd64;
      5'd11: a = 16'd32;
      5'd12: a = 16'd16;
      5'd13: a = 16'd8;
      5'd14: a = 16'd4;
      5'd15: a = 16'd2;
      5'd16: a = 16'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tme_if.sv
// Valid/ready channel interfaces: pose words in, estimate words out.
// Depends on tme_pkg for field widths.
`default_nettype none
interface tme_pose_if #(
  parameter int unsigned COORD_BITS = tme_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface tme_est_if;
  logic                              valid;
  logic                              ready;
  logic [tme_pkg::SPEED_W-1:0]       speed;
  logic                              speed_valid;
  logic signed [tme_pkg::HEAD_W-1:0] heading;
  logic                              heading_valid;
  logic [tme_pkg::CONF_W-1:0]        confidence;

  modport source (output valid, output speed, output speed_valid, output heading,
                  output heading_valid, output confidence, input ready);
  modport sink   (input valid, input speed, input speed_valid, input heading,
                  input heading_valid, input confidence, output ready);
endinterface
`default_nettype wire

FILE: rtl/track_motion_estimator_core.sv
// Each pose word walks back through the history for the larger of the speed window and
// the heading steps (at most nine for heading); the root width is 31 at default widths.
// One pose is in work at a time, and a new one is taken only in the idle state.
// A new pose is taken while the previous estimate still waits in the output register.
// Reset clears control state only; the history memory needs no clearing pass.
`default_nettype none
`include "track_motion_estimator_core_macros.svh"
module track_motion_estimator_core #(
  parameter int unsigned MAX_DEPTH  = tme_pkg::MAX_DEPTH_DEF,
  parameter int unsigned COORD_BITS = tme_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tme_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tme_pkg::CFG_W-1:0]       cfg_wdata_i,
  tme_pose_if.sink                             pose_i,
  tme_est_if.source                            est_o
);

  localparam int unsigned AW    = $clog2(MAX_DEPTH);
  localparam int unsigned CW    = $clog2(MAX_DEPTH + 1);
  localparam int unsigned KW    = (CW > tme_pkg::CFG_W) ? CW : tme_pkg::CFG_W;
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned PW    = tme_pkg::WT_W + 1 + DW;
  localparam int unsigned SW    = PW + 4;
  localparam int unsigned AIW   = tme_pkg::ANG_IN_W;
  localparam int unsigned RAD_W = (2 * DW > 2 * AIW) ? 2 * DW : 2 * AIW;
  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned SUM_W = RT_W + tme_pkg::CFG_W;
  localparam int unsigned CNF_W = RT_W + 10;
  localparam int unsigned DIV_N = (SUM_W + 1 > CNF_W) ? SUM_W + 1 : CNF_W;
  localparam int unsigned WS_W  = tme_pkg::WS_W;
  localparam int unsigned CMP_W = RT_W + 10;
  localparam logic signed [SW-1:0] NORM_LIM = SW'(64'sd1 <<< (AIW - 1));

  tme_pkg::tme_state_e state_q, state_d;

  logic [tme_pkg::CFG_W-1:0] hist_len_q, smooth_q;
  logic [CW-1:0]             pc_q;
  logic [AW-1:0]             newest_q, rd_ptr_q, newest_nx;
  logic                      have_prev_q;
  logic [KW-1:0]             k_q, ws_q, n_q, tot_q;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, cur_x, cur_y;
  logic signed [DW-1:0]         dx_q, dy_q;
  logic [RAD_W-1:0]             sq_q, rad_q;
  logic signed [SW-1:0]         sx_q, sy_q;
  logic [WS_W-1:0]              wsum_q;
  logic [SUM_W-1:0]             sum_q;
  logic                         spd_ok_q, head_pc_ok_q, head_ok_q, big_q;
  logic [RT_W-1:0]              m_q;
  logic [tme_pkg::SPEED_W-1:0]  speed_q;
  logic signed [tme_pkg::HEAD_W-1:0] heading_q;
  logic [tme_pkg::CONF_W-1:0]   conf_q;

  logic                              est_valid_q, est_spd_ok_q, est_head_ok_q;
  logic [tme_pkg::SPEED_W-1:0]       est_speed_q;
  logic signed [tme_pkg::HEAD_W-1:0] est_heading_q;
  logic [tme_pkg::CONF_W-1:0]        est_conf_q;

  // Combinational helpers
  logic                  pose_ready, accept, store, mem_re, load_out;
  logic [KW-1:0]         len_eff, pc1, pc_new, w_eff, pcm1, ws_c, n_c, tot_c, k_next;
  logic                  k_lt_ws, k_lt_n, more, big_now, cmp_ok, cmp_full;
  logic [2*COORD_BITS-1:0] rdata;
  logic signed [2*DW-1:0]  dxx, dyy;
  logic signed [PW-1:0]    wprod_x, wprod_y;
  logic signed [17:0]      wt_s;
  logic [tme_pkg::WT_W-1:0] wt;
  logic signed [AIW-1:0]   sx31, sy31;
  logic signed [2*AIW-1:0] sxx, syy;
  logic [CMP_W-1:0]        m30, m5, w512, w256;
  logic                    sqrt_start, div_start, cor_start;
  logic [DIV_N-1:0]        div_num, div_quot;
  logic [WS_W-1:0]         div_den;
  logic [RT_W-1:0]         root;
  logic signed [tme_pkg::HEAD_W-1:0] angle;
  tme_pkg::unit_stat_t     sqrt_stat, div_stat, cor_stat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_len_q <= tme_pkg::HIST_LEN_RST;
      smooth_q   <= tme_pkg::SMOOTH_RST;
    end else if (cfg_we_i) begin
      unique case (tme_pkg::cfg_reg_e'(cfg_idx_i))
        tme_pkg::REG_HIST_LEN: hist_len_q <= cfg_wdata_i;
        tme_pkg::REG_SMOOTH:   smooth_q   <= cfg_wdata_i;
      endcase
    end
  end

  // Insertion bookkeeping and step plan
  always_comb begin
    len_eff   = (KW'(hist_len_q) > KW'(MAX_DEPTH)) ? KW'(MAX_DEPTH) : KW'(hist_len_q);
    store     = (len_eff != '0);
    pc1       = KW'(pc_q) + 1'b1;
    pc_new    = (pc1 > len_eff) ? len_eff : pc1;
    newest_nx = (newest_q == AW'(MAX_DEPTH - 1)) ? '0 : newest_q + 1'b1;
    w_eff     = (smooth_q == '0) ? KW'(1) : KW'(smooth_q);
    pcm1      = KW'(pc_q) - 1'b1;
    ws_c      = (pc_q >= CW'(4)) ? ((w_eff > pcm1) ? pcm1 : w_eff) : '0;
    n_c       = (pc_q >= CW'(3)) ? ((pcm1 > KW'(tme_pkg::NUM_WT)) ?
                                    KW'(tme_pkg::NUM_WT) : pcm1) : '0;
    tot_c     = (ws_c > n_c) ? ws_c : n_c;
    k_next    = k_q + 1'b1;
    k_lt_ws   = (k_q < ws_q);
    k_lt_n    = (k_q < n_q);
    more      = (k_next < tot_q);
  end

  // Step arithmetic
  always_comb begin
    cur_x   = rdata[COORD_BITS-1:0];
    cur_y   = rdata[2*COORD_BITS-1:COORD_BITS];
    dxx     = dx_q * dx_q;
    dyy     = dy_q * dy_q;
    wt      = tme_pkg::fall_wt(k_q[3:0]);
    wt_s    = $signed({1'b0, wt});
    wprod_x = wt_s * dx_q;
    wprod_y = wt_s * dy_q;
    sx31    = sx_q[AIW-1:0];
    sy31    = sy_q[AIW-1:0];
    sxx     = sx31 * sx31;
    syy     = sy31 * sy31;
    big_now = (sx_q >= NORM_LIM) || (sx_q <= -NORM_LIM) ||
              (sy_q >= NORM_LIM) || (sy_q <= -NORM_LIM);
    // 30*m >= 512*W is the movement test, 5*m >= 256*W saturates confidence
    m30      = CMP_W'(m_q) * CMP_W'(30);
    m5       = CMP_W'(m_q) * CMP_W'(5);
    w512     = CMP_W'(wsum_q) << 9;
    w256     = CMP_W'(wsum_q) << 8;
    cmp_ok   = (m30 >= w512);
    cmp_full = (m5 >= w256);
    if (state_q == tme_pkg::S_SPD) begin
      div_num = DIV_N'({1'b0, sum_q}) + DIV_N'(ws_q >> 1);
      div_den = WS_W'(ws_q);
    end else begin
      div_num = DIV_N'(CMP_W'(m_q) * CMP_W'(640));
      div_den = wsum_q;
    end
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_d    = state_q;
    pose_ready = 1'b0;
    mem_re     = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      tme_pkg::S_IDLE: begin
        pose_ready = 1'b1;
        if (pose_i.valid) state_d = tme_pkg::S_PREP;
      end
      tme_pkg::S_PREP:  state_d = (tot_c == '0) ? tme_pkg::S_DONE : tme_pkg::S_FETCH;
      tme_pkg::S_FETCH: begin
        mem_re  = 1'b1;
        state_d = tme_pkg::S_LOAD;
      end
      tme_pkg::S_LOAD:  state_d = have_prev_q ? tme_pkg::S_SQX : tme_pkg::S_FETCH;
      tme_pkg::S_SQX:   state_d = tme_pkg::S_SQY;
      tme_pkg::S_SQY:   state_d = tme_pkg::S_ACCX;
      tme_pkg::S_ACCX:  state_d = tme_pkg::S_ACCY;
      tme_pkg::S_ACCY:  state_d = k_lt_ws ? tme_pkg::S_ROOT : tme_pkg::S_NEXT;
      tme_pkg::S_ROOT: begin
        sqrt_start = 1'b1;
        state_d    = tme_pkg::S_ROOT_WAIT;
      end
      tme_pkg::S_ROOT_WAIT: if (sqrt_stat.done) state_d = tme_pkg::S_NEXT;
      tme_pkg::S_NEXT:  state_d = more ? tme_pkg::S_FETCH : tme_pkg::S_SPD;
      tme_pkg::S_SPD: begin
        if (spd_ok_q) begin
          div_start = 1'b1;
          state_d   = tme_pkg::S_SPD_WAIT;
        end else begin
          state_d   = tme_pkg::S_NEG;
        end
      end
      tme_pkg::S_SPD_WAIT: if (div_stat.done) state_d = tme_pkg::S_NEG;
      tme_pkg::S_NEG:   state_d = head_pc_ok_q ? tme_pkg::S_NORM : tme_pkg::S_DONE;
      tme_pkg::S_NORM: begin
        if (!big_now) state_d = big_q ? tme_pkg::S_ANG : tme_pkg::S_MX;
      end
      tme_pkg::S_MX:    state_d = tme_pkg::S_MY;
      tme_pkg::S_MY:    state_d = tme_pkg::S_MAG;
      tme_pkg::S_MAG: begin
        sqrt_start = 1'b1;
        state_d    = tme_pkg::S_MAG_WAIT;
      end
      tme_pkg::S_MAG_WAIT: if (sqrt_stat.done) state_d = tme_pkg::S_CMP;
      tme_pkg::S_CMP: begin
        if (!cmp_ok) begin
          state_d = tme_pkg::S_DONE;
        end else if (cmp_full) begin
          state_d = tme_pkg::S_ANG;
        end else begin
          div_start = 1'b1;
          state_d   = tme_pkg::S_CONF_WAIT;
        end
      end
      tme_pkg::S_CONF_WAIT: if (div_stat.done) state_d = tme_pkg::S_ANG;
      tme_pkg::S_ANG: begin
        cor_start = 1'b1;
        state_d   = tme_pkg::S_ANG_WAIT;
      end
      tme_pkg::S_ANG_WAIT: if (cor_stat.done) state_d = tme_pkg::S_DONE;
      tme_pkg::S_DONE: begin
        if (!est_valid_q || est_o.ready) begin
          load_out = 1'b1;
          state_d  = tme_pkg::S_IDLE;
        end
      end
    endcase
  end

  assign accept = pose_i.valid && pose_ready;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tme_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // History pointers and walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      newest_q    <= '0;
      rd_ptr_q    <= '0;
      have_prev_q <= 1'b0;
      k_q         <= '0;
      ws_q        <= '0;
      n_q         <= '0;
      tot_q       <= '0;
    end else begin
      if (accept && store) begin
        newest_q <= newest_nx;
        pc_q     <= CW'(pc_new);
      end
      if (state_q == tme_pkg::S_PREP) begin
        ws_q        <= ws_c;
        n_q         <= n_c;
        tot_q       <= tot_c;
        k_q         <= '0;
        rd_ptr_q    <= newest_q;
        have_prev_q <= 1'b0;
      end
      if (state_q == tme_pkg::S_FETCH) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_DEPTH - 1) : rd_ptr_q - 1'b1;
      end
      if (state_q == tme_pkg::S_LOAD) have_prev_q <= 1'b1;
      if (state_q == tme_pkg::S_NEXT) k_q <= k_next;
    end
  end

  // Estimation datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tme_pkg::S_PREP: begin
        sx_q         <= '0;
        sy_q         <= '0;
        wsum_q       <= '0;
        sum_q        <= '0;
        speed_q      <= '0;
        heading_q    <= '0;
        conf_q       <= '0;
        head_ok_q    <= 1'b0;
        big_q        <= 1'b0;
        spd_ok_q     <= (pc_q >= CW'(4));
        head_pc_ok_q <= (pc_q >= CW'(3));
      end
      tme_pkg::S_LOAD: begin
        // Newer pose minus older pose
        dx_q     <= DW'(prev_x_q) - DW'(cur_x);
        dy_q     <= DW'(prev_y_q) - DW'(cur_y);
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
      end
      tme_pkg::S_SQX: sq_q  <= RAD_W'($unsigned(dxx));
      tme_pkg::S_SQY: rad_q <= sq_q + RAD_W'($unsigned(dyy));
      tme_pkg::S_ACCX: if (k_lt_n) sx_q <= sx_q + SW'(wprod_x);
      tme_pkg::S_ACCY: begin
        if (k_lt_n) begin
          sy_q   <= sy_q + SW'(wprod_y);
          wsum_q <= wsum_q + WS_W'(wt);
        end
      end
      tme_pkg::S_ROOT_WAIT: if (sqrt_stat.done) sum_q <= sum_q + SUM_W'(root);
      tme_pkg::S_SPD_WAIT: begin
        if (div_stat.done) begin
          speed_q <= (div_quot > DIV_N'({tme_pkg::SPEED_W{1'b1}})) ?
                     {tme_pkg::SPEED_W{1'b1}} : div_quot[tme_pkg::SPEED_W-1:0];
        end
      end
      tme_pkg::S_NEG: sy_q <= -sy_q;
      tme_pkg::S_NORM: begin
        if (big_now) begin
          sx_q  <= sx_q >>> 1;
          sy_q  <= sy_q >>> 1;
          big_q <= 1'b1;
        end else if (big_q) begin
          head_ok_q <= 1'b1;
          conf_q    <= tme_pkg::CONF_FULL;
        end
      end
      tme_pkg::S_MX: sq_q  <= RAD_W'($unsigned(sxx));
      tme_pkg::S_MY: rad_q <= sq_q + RAD_W'($unsigned(syy));
      tme_pkg::S_MAG_WAIT: if (sqrt_stat.done) m_q <= root;
      tme_pkg::S_CMP: begin
        head_ok_q <= cmp_ok;
        if (cmp_full) conf_q <= tme_pkg::CONF_FULL;
      end
      tme_pkg::S_CONF_WAIT: if (div_stat.done) conf_q <= div_quot[tme_pkg::CONF_W-1:0];
      tme_pkg::S_ANG_WAIT: if (cor_stat.done) heading_q <= angle;
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_valid_q <= 1'b0;
    end else if (load_out) begin
      est_valid_q <= 1'b1;
    end else if (est_o.ready) begin
      est_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      est_speed_q   <= speed_q;
      est_spd_ok_q  <= spd_ok_q;
      est_heading_q <= heading_q;
      est_head_ok_q <= head_ok_q;
      est_conf_q    <= conf_q;
    end
  end

  assign pose_i.ready        = pose_ready;
  assign est_o.valid         = est_valid_q;
  assign est_o.speed         = est_speed_q;
  assign est_o.speed_valid   = est_spd_ok_q;
  assign est_o.heading       = est_heading_q;
  assign est_o.heading_valid = est_head_ok_q;
  assign est_o.confidence    = est_conf_q;

  tme_hist_mem #(
    .DEPTH  (MAX_DEPTH),
    .DATA_W (2 * COORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (accept && store),
    .waddr_i (newest_nx),
    .wdata_i ({pose_i.pos_y, pose_i.pos_x}),
    .re_i    (mem_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  tme_sqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad_q),
    .root_o  (root),
    .stat_o  (sqrt_stat)
  );

  tme_div #(
    .NUM_W (DIV_N),
    .DEN_W (WS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  tme_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .x_i     (sx31),
    .y_i     (sy31),
    .angle_o (angle),
    .stat_o  (cor_stat)
  );

  // Checks
  `TME_ASSERT_NXT(a_busy_after_accept, accept, !pose_i.ready, "pose taken while busy")
  `TME_ASSERT_IMP(a_speed_needs_four, est_o.valid && est_o.speed_valid, pc_q >= CW'(4),
                  "speed valid with fewer than four poses")
  `TME_ASSERT_IMP(a_no_heading_zero, est_o.valid && !est_o.heading_valid,
                  est_o.heading == '0 && est_o.confidence == '0,
                  "invalid heading carries data")
  `TME_ASSERT(a_one_unit_busy,
              $countones({sqrt_stat.busy, div_stat.busy, cor_stat.busy}) <= 1,
              "arithmetic units overlap")

endmodule
`default_nettype wire

FILE: rtl/tme_hist_mem.sv
// Pose history ring: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module tme_hist_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tme_sqrt.sv
// Bit-serial integer square root (floor), one root bit per cycle.
// Depends on tme_pkg for the unit status word.
`default_nettype none
module tme_sqrt #(
  parameter int unsigned RAD_W = 62
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [RAD_W-1:0]       rad_i,
  output logic      [RAD_W/2-1:0]     root_o,
  output tme_pkg::unit_stat_t         stat_o
);

  localparam int unsigned RT_W  = RAD_W / 2;
  localparam int unsigned CNT_W = $clog2(RT_W + 1);

  logic [RAD_W-1:0] rad_q;
  logic [RT_W+1:0]  rem_q;
  logic [RT_W-1:0]  root_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [1:0]      pair;
  logic [RT_W+1:0] rem_t, trial;
  logic            fits;

  // Trial subtraction of the next digit pair
  always_comb begin
    pair  = rad_q[RAD_W-1 -: 2];
    rem_t = {rem_q[RT_W-1:0], pair};
    trial = {root_q, 2'b01};
    fits  = (rem_t >= trial);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(RT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= fits ? (rem_t - trial) : rem_t;
      root_q <= {root_q[RT_W-2:0], fits};
    end
  end

  assign root_o      = root_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

FILE: rtl/tme_div.sv
// Restoring unsigned divider, one quotient bit per cycle (floor).
// Depends on tme_pkg for the unit status word.
`default_nettype none
module tme_div #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 19
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NUM_W-1:0]   num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  output logic      [NUM_W-1:0]   quot_o,
  output tme_pkg::unit_stat_t     stat_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  logic [DEN_W:0] rem_t, rem_s;
  logic           fits;

  always_comb begin
    rem_t = {rem_q, num_q[NUM_W-1]};
    fits  = (rem_t >= {1'b0, den_q});
    rem_s = rem_t - {1'b0, den_q};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], fits};
      rem_q <= fits ? rem_s[DEN_W-1:0] : rem_t[DEN_W-1:0];
    end
  end

  assign quot_o      = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

FILE: rtl/tme_cordic.sv
// Iterative vectoring CORDIC: angle of (x, y) in Q16, rounded to Q13 and clamped.
// Depends on tme_pkg for the atan table and angle constants.
`default_nettype none
module tme_cordic (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [tme_pkg::ANG_IN_W-1:0] x_i,
  input  wire logic signed [tme_pkg::ANG_IN_W-1:0] y_i,
  output logic signed      [tme_pkg::HEAD_W-1:0]   angle_o,
  output tme_pkg::unit_stat_t                      stat_o
);

  localparam int unsigned X_W = tme_pkg::ANG_IN_W + 3;
  localparam int unsigned Z_W = tme_pkg::Z_W;

  logic signed [X_W-1:0] x_q, y_q, xs, ys, x0, y0;
  logic signed [Z_W-1:0] z_q, at, zr, zc;
  logic [4:0]            i_q;
  logic                  busy_q, done_q;

  always_comb begin
    x0 = X_W'(x_i);
    y0 = X_W'(y_i);
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = $signed({{(Z_W - tme_pkg::ATAN_W){1'b0}}, tme_pkg::atan_q16(i_q)});
    // Round Q16 to Q13 and clamp to the heading range
    zr = (z_q + Z_W'(4)) >>> 3;
    if (zr > tme_pkg::HEADING_LIMIT) begin
      zc = tme_pkg::HEADING_LIMIT;
    end else if (zr < -tme_pkg::HEADING_LIMIT) begin
      zc = -tme_pkg::HEADING_LIMIT;
    end else begin
      zc = zr;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      i_q    <= '0;
    end else if (busy_q) begin
      i_q <= i_q + 1'b1;
      if (i_q == 5'(tme_pkg::CORDIC_N - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Left half plane is folded over by a rotation of pi first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= (y_i >= 0) ? tme_pkg::PI_Q16 : -tme_pkg::PI_Q16;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  assign angle_o     = zc[tme_pkg::HEAD_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire
